### rtl/prm_pkg.sv
// Shared types and constants of the probe round-trip matcher.
`default_nettype none
package prm_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PCOUNT_W    = 11;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = PCOUNT_W'(1024);
  localparam logic [31:0]         PROBE_MAGIC  = 32'h5049_4E47;
  localparam logic                REG_PROBE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_REPLY = 2'd1,
    OP_SWEEP = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_SENT    = 3'd0,
    ST_OK      = 3'd1,
    ST_RANGE   = 3'd2,
    ST_DUP     = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_LIMIT   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CMD_SEND  = 3'd0,
    CMD_LIMIT = 3'd1,
    CMD_RANGE = 3'd2,
    CMD_DUP   = 3'd3,
    CMD_REPLY = 3'd4,
    CMD_SWEEP = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] seq_in;
    logic [31:0] magic_in;
    logic [63:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] seq_out;
    logic [63:0] send_time;
    logic [63:0] recv_time;
    logic [63:0] rtt_ns;
  } result_t;

  // classified transaction handed from front to back
  typedef struct packed {
    cmd_kind_e        kind;
    logic [IDX_W-1:0] idx;
    logic [31:0]      seq;
    logic [63:0]      stamp;
  } cmd_t;

  typedef struct packed {
    logic        replied;
    logic [63:0] send_time;
  } entry_t;

endpackage
`default_nettype wire

### rtl/probe_rtt_matcher.sv
// Top level of the probe round-trip matcher.
//
// Command channel: a transaction (send, reply or timeout sweep) is taken at a
// rising edge with start high and busy low. The front end classifies it and
// assigns sequence numbers; a two-entry queue decouples it from the back end,
// which owns the probe table memory. busy is high only while the queue is full.
// Result channel: done_o marks a result on result_o for exactly one cycle; the
// receiver cannot hold it off. Replies with a wrong magic word, sweeps of
// answered, unsent or out-of-range entries and unused opcodes give none.
// Path: queue slot, back end command and table-read registers, then done_o.
// The back end finishes one transaction before it pops the next: a
// read-modify-write of the single-port table (read, then update).
// APB: probe_count at byte address 0, pready always high; the user must write
// only while the block is idle, which the block itself does not enforce.
// Reset: next sequence number clears to zero and probe_count returns to 1024.
// An entry counts as sent exactly when its index is below the next sequence
// number, so the table needs no clearing pass and is usable right after reset.
`default_nettype none
module probe_rtt_matcher (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire prm_pkg::in_item_t           in_item_i,
  output logic                             done_o,
  output prm_pkg::result_t                 result_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [prm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [prm_pkg::CNT_W-1:0] limit;
  logic                      push;
  logic                      pop;
  logic                      q_empty;
  logic                      q_full;
  prm_pkg::cmd_t             cmd_in;
  prm_pkg::cmd_t             cmd_out;

  assign busy = q_full;

  prm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  prm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .in_item_i (in_item_i),
    .limit_i   (limit),
    .full_i    (q_full),
    .push_o    (push),
    .cmd_o     (cmd_in)
  );

  prm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  prm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (q_empty),
    .cmd_i    (cmd_out),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

### rtl/prm_cfg.sv
// APB register file: probe count and the derived active limit.
`default_nettype none
module prm_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [prm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [prm_pkg::CNT_W-1:0]        limit_o
);

  logic [prm_pkg::PCOUNT_W-1:0] probe_count_q, probe_count_d;
  logic                         reg_sel;

  // register index is the word address; byte offset bits are ignored
  assign reg_sel = (paddr[2] == prm_pkg::REG_PROBE_COUNT);
  assign pready  = 1'b1;

  always_comb begin
    probe_count_d = probe_count_q;
    if (psel && penable && pwrite && reg_sel) begin
      probe_count_d = pwdata[prm_pkg::PCOUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_count_q <= prm_pkg::PCOUNT_RESET;
    end else begin
      probe_count_q <= probe_count_d;
    end
  end

  assign prdata = reg_sel ? 32'(probe_count_q) : 32'd0;

  assign limit_o = (32'(probe_count_q) < 32'(prm_pkg::TABLE_DEPTH))
                 ? prm_pkg::CNT_W'(probe_count_q)
                 : prm_pkg::CNT_W'(prm_pkg::TABLE_DEPTH);

endmodule
`default_nettype wire

### rtl/prm_front.sv
// Front end: accepts transactions, assigns sequence numbers, classifies.
`default_nettype none
module prm_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  input  wire prm_pkg::in_item_t        in_item_i,
  input  wire logic [prm_pkg::CNT_W-1:0] limit_i,
  input  wire logic                     full_i,
  output logic                          push_o,
  output prm_pkg::cmd_t                 cmd_o
);

  logic [prm_pkg::CNT_W-1:0] next_seq_q, next_seq_d;
  logic                      accept;
  logic [31:0]               seq_ext;
  logic [31:0]               lim_ext;

  assign accept  = start && !full_i;
  assign seq_ext = 32'(next_seq_q);
  assign lim_ext = 32'(limit_i);

  always_comb begin
    push_o      = 1'b0;
    next_seq_d  = next_seq_q;
    cmd_o.kind  = prm_pkg::CMD_DUP;
    cmd_o.idx   = in_item_i.seq_in[prm_pkg::IDX_W-1:0];
    cmd_o.seq   = in_item_i.seq_in;
    cmd_o.stamp = in_item_i.time_now;
    if (accept) begin
      unique case (in_item_i.operation)
        prm_pkg::OP_SEND: begin
          push_o    = 1'b1;
          cmd_o.seq = seq_ext;
          if (next_seq_q >= limit_i) begin
            cmd_o.kind = prm_pkg::CMD_LIMIT;
          end else begin
            cmd_o.kind = prm_pkg::CMD_SEND;
            cmd_o.idx  = next_seq_q[prm_pkg::IDX_W-1:0];
            next_seq_d = next_seq_q + 1'b1;
          end
        end
        prm_pkg::OP_REPLY: begin
          if (in_item_i.magic_in == prm_pkg::PROBE_MAGIC) begin
            push_o = 1'b1;
            // entries below next_seq have been written by a send
            if (in_item_i.seq_in >= lim_ext) begin
              cmd_o.kind = prm_pkg::CMD_RANGE;
            end else if (in_item_i.seq_in < seq_ext) begin
              cmd_o.kind = prm_pkg::CMD_REPLY;
            end else begin
              cmd_o.kind = prm_pkg::CMD_DUP;
            end
          end
        end
        prm_pkg::OP_SWEEP: begin
          if (in_item_i.seq_in < lim_ext && in_item_i.seq_in < seq_ext) begin
            push_o     = 1'b1;
            cmd_o.kind = prm_pkg::CMD_SWEEP;
          end
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_seq_q <= '0;
    end else begin
      next_seq_q <= next_seq_d;
    end
  end

endmodule
`default_nettype wire

### rtl/prm_fifo.sv
// Short command queue between front and back.
`default_nettype none
module prm_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire prm_pkg::cmd_t cmd_i,
  input  wire logic          pop_i,
  output prm_pkg::cmd_t      cmd_o,
  output logic               empty_o,
  output logic               full_o
);

  prm_pkg::cmd_t                slot_q [prm_pkg::QUEUE_DEPTH];
  logic [prm_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [prm_pkg::QCNT_W-1:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == prm_pkg::QCNT_W'(prm_pkg::QUEUE_DEPTH));
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == prm_pkg::QPTR_W'(prm_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == prm_pkg::QPTR_W'(prm_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/prm_back.sv
// Back end: probe table read-modify-write and result register.
`default_nettype none
module prm_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          empty_i,
  input  wire prm_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               done_o,
  output prm_pkg::result_t   result_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                     state_q;
  prm_pkg::cmd_t              cmd_q;
  logic                       done_q;
  prm_pkg::result_t           result_q;

  prm_pkg::entry_t            mem [prm_pkg::TABLE_DEPTH];
  prm_pkg::entry_t            rd_q;
  logic                       we;
  logic [prm_pkg::IDX_W-1:0]  waddr;
  prm_pkg::entry_t            wdata;

  logic                       fire;
  prm_pkg::result_t           res;

  assign pop_o = (state_q == S_IDLE) && !empty_i;

  // sends write on pop; first reply marks the entry in the execute cycle
  always_comb begin
    we    = 1'b0;
    waddr = cmd_i.idx;
    wdata = '{replied: 1'b0, send_time: cmd_i.stamp};
    if (pop_o && cmd_i.kind == prm_pkg::CMD_SEND) begin
      we = 1'b1;
    end else if (state_q == S_EXEC && cmd_q.kind == prm_pkg::CMD_REPLY && !rd_q.replied) begin
      we    = 1'b1;
      waddr = cmd_q.idx;
      wdata = '{replied: 1'b1, send_time: rd_q.send_time};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (pop_o) begin
      rd_q <= mem[cmd_i.idx];
    end
  end

  always_comb begin
    fire        = 1'b0;
    res         = '0;
    res.seq_out = cmd_q.seq;
    unique case (cmd_q.kind)
      prm_pkg::CMD_SEND: begin
        fire          = 1'b1;
        res.status    = prm_pkg::ST_SENT;
        res.send_time = cmd_q.stamp;
      end
      prm_pkg::CMD_LIMIT: begin
        fire       = 1'b1;
        res.status = prm_pkg::ST_LIMIT;
      end
      prm_pkg::CMD_RANGE: begin
        fire          = 1'b1;
        res.status    = prm_pkg::ST_RANGE;
        res.recv_time = cmd_q.stamp;
      end
      prm_pkg::CMD_DUP: begin
        fire          = 1'b1;
        res.status    = prm_pkg::ST_DUP;
        res.recv_time = cmd_q.stamp;
      end
      prm_pkg::CMD_REPLY: begin
        fire          = 1'b1;
        res.recv_time = cmd_q.stamp;
        if (!rd_q.replied) begin
          res.status    = prm_pkg::ST_OK;
          res.send_time = rd_q.send_time;
          res.rtt_ns    = cmd_q.stamp - rd_q.send_time;
        end else begin
          res.status = prm_pkg::ST_DUP;
        end
      end
      prm_pkg::CMD_SWEEP: begin
        if (!rd_q.replied) begin
          fire          = 1'b1;
          res.status    = prm_pkg::ST_TIMEOUT;
          res.send_time = rd_q.send_time;
        end
      end
      default: begin
        fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            cmd_q   <= cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          done_q   <= fire;
          result_q <= res;
          state_q  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

### rtl/prm_checker.sv
// Port-level assertions for the probe round-trip matcher, bound to the top.
`default_nettype none
module prm_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              done_o,
  input wire prm_pkg::result_t  result_o
);

  // back end finishes one transaction before it takes the next
  a_done_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results on consecutive cycles");

  a_ok_rtt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == prm_pkg::ST_OK) |->
      (result_o.rtt_ns == result_o.recv_time - result_o.send_time))
    else $error("rtt does not match receive minus send time");

  a_send_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == prm_pkg::ST_SENT ||
                result_o.status == prm_pkg::ST_LIMIT)) |->
      (result_o.recv_time == 64'd0 && result_o.rtt_ns == 64'd0))
    else $error("send result carries receive data");

  a_timeout_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == prm_pkg::ST_TIMEOUT) |->
      (result_o.recv_time == 64'd0 && result_o.rtt_ns == 64'd0 &&
       result_o.seq_out < 32'(prm_pkg::TABLE_DEPTH)))
    else $error("malformed timeout result");

endmodule

bind probe_rtt_matcher prm_checker u_prm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the probe round-trip matcher.
module testbench;
  import prm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 10;
  localparam int PHASE_ITEMS = 370;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  in_item_t            in_item = '0;
  logic                done_o;
  result_t             result_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  probe_rtt_matcher u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .in_item_i (in_item),
    .done_o    (done_o),
    .result_o  (result_o),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // probe table as the block should hold it
  logic [PCOUNT_W-1:0] model_count = PCOUNT_RESET;
  logic [PCOUNT_W-1:0] next_num = '0;
  bit                  sent_mark [TABLE_DEPTH];
  bit                  reply_mark [TABLE_DEPTH];
  logic [63:0]         stamp_mem [TABLE_DEPTH];

  in_item_t    probe_cmds[$];
  result_t     awaited_results[$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  // generator's view of sequence numbering, used only to aim replies and sweeps
  int unsigned gen_next = 0;
  int unsigned gen_lim = TABLE_DEPTH;
  logic [63:0] gen_clock;

  function automatic void resolve_probe(in_item_t it);
    result_t             r;
    logic [PCOUNT_W-1:0] lim;
    bit                  emit;
    logic [IDX_W-1:0]    slot;
    logic [IDX_W-1:0]    new_slot;
    lim      = (model_count > TABLE_DEPTH) ? PCOUNT_W'(TABLE_DEPTH) : model_count;
    r        = '0;
    emit     = 1'b0;
    // table index is only used once the number is known to be in range
    slot     = it.seq_in[IDX_W-1:0];
    new_slot = next_num[IDX_W-1:0];
    case (op_e'(it.operation))
      OP_SEND: begin
        emit = 1'b1;
        r.seq_out = 32'(next_num);
        if (next_num >= lim) begin
          r.status = ST_LIMIT;
        end else begin
          stamp_mem[new_slot]  = it.time_now;
          sent_mark[new_slot]  = 1'b1;
          reply_mark[new_slot] = 1'b0;
          r.status    = ST_SENT;
          r.send_time = it.time_now;
          next_num    = next_num + 1'b1;
        end
      end
      OP_REPLY: begin
        if (it.magic_in == PROBE_MAGIC) begin
          emit = 1'b1;
          r.seq_out   = it.seq_in;
          r.recv_time = it.time_now;
          if (it.seq_in >= lim) begin
            r.status = ST_RANGE;
          end else if (sent_mark[slot] && !reply_mark[slot]) begin
            reply_mark[slot] = 1'b1;
            r.status    = ST_OK;
            r.send_time = stamp_mem[slot];
            r.rtt_ns    = it.time_now - stamp_mem[slot];
          end else begin
            r.status = ST_DUP;
          end
        end
      end
      OP_SWEEP: begin
        if (it.seq_in < lim && sent_mark[slot] && !reply_mark[slot]) begin
          emit = 1'b1;
          r.status    = ST_TIMEOUT;
          r.seq_out   = it.seq_in;
          r.send_time = stamp_mem[slot];
        end
      end
      default: ;
    endcase
    if (emit) awaited_results.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // driver: one transaction per start, random idle cycles unless calm
  always @(posedge clk_i) begin : drive
    bit took;
    bit rest;
    took = rst_ni && start && !busy;
    if (took) resolve_probe(in_item);
    if (!start || took) begin
      rest = !calm && ($urandom_range(0, 99) < 37);
      if (rst_ni && !rest && probe_cmds.size() > 0) begin
        start   <= 1'b1;
        in_item <= probe_cmds.pop_front();
      end else begin
        start   <= 1'b0;
        in_item <= '{operation: 2'($urandom), seq_in: $urandom, magic_in: $urandom,
                     time_now: {$urandom, $urandom}};
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch
    result_t want;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d seq_out %0h", result_o.status, result_o.seq_out);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 64'(want.status), 64'(result_o.status));
        check_field("seq_out", 64'(want.seq_out), 64'(result_o.seq_out));
        check_field("send_time", want.send_time, result_o.send_time);
        check_field("recv_time", want.recv_time, result_o.recv_time);
        check_field("rtt_ns", want.rtt_ns, result_o.rtt_ns);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [ADDR_W-1:0] a, input logic [31:0] d);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (a[ADDR_W-1:2] == REG_PROBE_COUNT) model_count = d[PCOUNT_W-1:0];
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic check_reg(input logic [ADDR_W-1:0] a, input logic [31:0] want);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $error("probe_count mismatch: expected %0h, got %0h", want, prdata);
      errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic set_count(input logic [31:0] d);
    write_reg({REG_PROBE_COUNT, 2'b00}, d);
    check_reg({REG_PROBE_COUNT, 2'b00}, 32'(d[PCOUNT_W-1:0]));
    gen_lim = (d[PCOUNT_W-1:0] > TABLE_DEPTH) ? TABLE_DEPTH : d[PCOUNT_W-1:0];
  endtask

  // wait for the block to go idle; no-result transactions get extra cycles
  task automatic drain();
    do @(posedge clk_i);
    while (probe_cmds.size() != 0 || start || awaited_results.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic void queue_item(logic [1:0] op, logic [31:0] seq, logic [31:0] magic,
                                     logic [63:0] t);
    probe_cmds.push_back('{operation: op, seq_in: seq, magic_in: magic, time_now: t});
    if (op == OP_SEND && gen_next < gen_lim) gen_next++;
  endfunction

  function automatic logic [31:0] recent_idx();
    int unsigned base;
    base = (gen_next < gen_lim) ? gen_next : gen_lim;
    if (base == 0) return 32'd0;
    return base - 1 - $urandom_range(0, (base - 1 < 20) ? base - 1 : 20);
  endfunction

  initial begin
    logic [31:0] counts [5];
    int          roll;
    counts = '{32'hFFFF_F840, 32'd300, 32'd100, 32'd1024, 32'd777};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_reg({REG_PROBE_COUNT, 2'b00}, 32'(PCOUNT_RESET));

    // single-probe run: send limit, wrapped rtt, duplicate, out of range, ignored items
    set_count(32'd1);
    queue_item(OP_SEND, $urandom, $urandom, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(OP_SEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
    queue_item(OP_REPLY, 32'd0, PROBE_MAGIC, 64'd5);
    queue_item(OP_REPLY, 32'd0, PROBE_MAGIC, 64'd6);
    queue_item(OP_REPLY, 32'd1, PROBE_MAGIC, 64'd7);
    queue_item(OP_REPLY, 32'hFFFF_FFFF, PROBE_MAGIC, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(OP_REPLY, 32'd0, ~PROBE_MAGIC, 64'd8);
    queue_item(OP_SWEEP, 32'd0, 32'd0, 64'd9);
    queue_item(OP_SWEEP, 32'hFFFF_FFFF, 32'd0, 64'd10);
    queue_item(2'd3, 32'd0, PROBE_MAGIC, 64'd11);
    drain();

    // full table; write to the unused register index must not land
    set_count(32'd1024);
    write_reg(3'd4, 32'd5);
    check_reg({REG_PROBE_COUNT, 2'b00}, 32'd1024);
    queue_item(OP_SEND, 32'd0, 32'd0, 64'h8000_0000_0000_0000);
    queue_item(OP_SWEEP, 32'd1, 32'd0, 64'd0);
    queue_item(OP_SWEEP, 32'd1023, 32'd0, 64'd0);
    queue_item(OP_REPLY, 32'd1023, PROBE_MAGIC, 64'd1);
    queue_item(OP_REPLY, 32'd1024, PROBE_MAGIC, 64'd2);
    queue_item(OP_REPLY, 32'd1, PROBE_MAGIC ^ 32'h1, 64'd3);
    queue_item(OP_REPLY, 32'd1, PROBE_MAGIC, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_item(OP_SWEEP, 32'd1, 32'd0, 64'd4);
    queue_item(OP_SEND, 32'd0, 32'd0, 64'd0);
    queue_item(OP_REPLY, 32'd2, PROBE_MAGIC, 64'd0);
    drain();

    // random phases; the third lowers the limit below the next sequence number
    foreach (counts[p]) begin
      set_count(counts[p]);
      calm = (p == 3);
      gen_clock = {$urandom, $urandom};
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        gen_clock += $urandom_range(1, 4000);
        roll = $urandom_range(0, 99);
        if (roll < 35)
          queue_item(OP_SEND, $urandom, $urandom, gen_clock);
        else if (roll < 65)
          queue_item(OP_REPLY, recent_idx(), PROBE_MAGIC, gen_clock);
        else if (roll < 78)
          queue_item(OP_SWEEP, recent_idx(), $urandom, gen_clock);
        else if (roll < 88)
          queue_item(OP_REPLY, $urandom_range(0, gen_lim + 8), PROBE_MAGIC, gen_clock);
        else
          queue_item(2'($urandom_range(0, 3)), $urandom, $urandom, {$urandom, $urandom});
      end
      drain();
      calm = 1'b0;
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
